FILE: rtl/core/url_percent_normalizer_defines.svh
// Assertion macros for the URL percent normalizer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef URL_PERCENT_NORMALIZER_DEFINES_SVH
`define URL_PERCENT_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define UPN_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle implication failed");

`define UPN_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define UPN_ASSERT_IMPL(lbl, ant, cons)

`define UPN_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

FILE: rtl/core/upn_pkg.sv
package upn_pkg;

  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_TWO  = 8'h32;  // '2'
  localparam logic [7:0] CH_FIVE = 8'h35;  // '5'

  // What goes out before the held digit.
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_PCT,
    PRE_PCT25
  } upn_pre_t;

  // What goes out after the held digit.
  typedef enum logic [1:0] {
    MAIN_NONE,
    MAIN_RAW,
    MAIN_ESC,
    MAIN_PCT25
  } upn_main_t;

  // One request from the front to the back: up to seven output bytes.
  typedef struct packed {
    upn_pre_t   pre;
    logic       held_en;
    logic [7:0] held;
    upn_main_t  main;
    logic [7:0] data;
    logic       last;
  } upn_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } upn_q_status_t;

endpackage

FILE: rtl/core/upn_in_if.sv
interface upn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/core/upn_out_if.sv
interface upn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/core/upn_front.sv
module upn_front (
  input  logic                   clk,
  input  logic                   rst_n,
  upn_in_if.sink                 in_chan,
  input  upn_pkg::upn_q_status_t q_status,
  output logic                   push_valid,
  output upn_pkg::upn_cmd_t      push_data,
  output logic                   mode_idle
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PCT,
    MODE_DIGIT
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [7:0]        held_r, held_nxt;
  upn_pkg::upn_cmd_t cmd;
  logic              accept;
  logic              is_hex;
  logic              is_esc;
  logic              is_pct;
  logic              emit;

  function automatic logic hex_ok(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Controls, space, DEL and above, and the unsafe symbols " < > [ \ ] ^ ` { | }.
  function automatic logic needs_escape(input logic [7:0] b);
    return (b <= 8'h20) || (b >= 8'h7f) || (b == 8'h22) || (b == 8'h3c) ||
           (b == 8'h3e) || (b == 8'h5b) || (b == 8'h5c) || (b == 8'h5d) ||
           (b == 8'h5e) || (b == 8'h60) || (b == 8'h7b) || (b == 8'h7c) ||
           (b == 8'h7d);
  endfunction

  assign accept       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !q_status.full;
  assign is_hex       = hex_ok(in_chan.in_byte);
  assign is_esc       = needs_escape(in_chan.in_byte);
  assign is_pct       = in_chan.in_byte == upn_pkg::CH_PCT;

  always_comb begin
    logic do_plain;
    do_plain     = 1'b0;
    mode_nxt     = MODE_IDLE;
    held_nxt     = held_r;
    cmd.pre      = upn_pkg::PRE_NONE;
    cmd.held_en  = 1'b0;
    cmd.held     = held_r;
    cmd.main     = upn_pkg::MAIN_NONE;
    cmd.data     = in_chan.in_byte;
    cmd.last     = in_chan.in_last;

    unique case (mode_r)
      MODE_PCT: begin
        if (is_hex) begin
          if (in_chan.in_last) begin
            cmd.pre  = upn_pkg::PRE_PCT25;
            cmd.main = upn_pkg::MAIN_RAW;
          end else begin
            mode_nxt = MODE_DIGIT;
            held_nxt = in_chan.in_byte;
          end
        end else begin
          cmd.pre  = upn_pkg::PRE_PCT25;
          do_plain = 1'b1;
        end
      end
      MODE_DIGIT: begin
        cmd.held_en = 1'b1;
        if (is_hex) begin
          // A complete escape passes through untouched.
          cmd.pre  = upn_pkg::PRE_PCT;
          cmd.main = upn_pkg::MAIN_RAW;
        end else begin
          cmd.pre  = upn_pkg::PRE_PCT25;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (is_pct) begin
        if (in_chan.in_last) begin
          cmd.main = upn_pkg::MAIN_PCT25;
        end else begin
          mode_nxt = MODE_PCT;
        end
      end else if (is_esc) begin
        cmd.main = upn_pkg::MAIN_ESC;
      end else begin
        cmd.main = upn_pkg::MAIN_RAW;
      end
    end
  end

  assign emit       = (cmd.pre != upn_pkg::PRE_NONE) || cmd.held_en ||
                      (cmd.main != upn_pkg::MAIN_NONE);
  assign push_valid = accept && emit;
  assign push_data  = cmd;
  assign mode_idle  = mode_r == MODE_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

FILE: rtl/core/upn_queue.sv
module upn_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  upn_pkg::upn_cmd_t      push_data,
  input  logic                   pop,
  output upn_pkg::upn_cmd_t      head_data,
  output upn_pkg::upn_q_status_t q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upn_pkg::upn_cmd_t entries_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;

  assign q_status.full  = cnt_r == CW'(DEPTH);
  assign q_status.empty = cnt_r == '0;
  assign head_data      = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/upn_back.sv
module upn_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  upn_pkg::upn_cmd_t      head_data,
  input  upn_pkg::upn_q_status_t q_status,
  output logic                   pop,
  upn_out_if.source              out_chan
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] len_pre, len_held, len_main, total;
  logic [2:0] main_off;
  logic       final_step;
  logic       load;
  logic [7:0] sel_byte;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  always_comb begin
    unique case (head_data.pre)
      upn_pkg::PRE_PCT:   len_pre = 3'd1;
      upn_pkg::PRE_PCT25: len_pre = 3'd3;
      default:            len_pre = 3'd0;
    endcase
    unique case (head_data.main)
      upn_pkg::MAIN_RAW:             len_main = 3'd1;
      upn_pkg::MAIN_ESC,
      upn_pkg::MAIN_PCT25:           len_main = 3'd3;
      default:                       len_main = 3'd0;
    endcase
  end

  assign len_held   = {2'b00, head_data.held_en};
  assign total      = len_pre + len_held + len_main;
  assign final_step = idx_r == total - 3'd1;
  assign main_off   = idx_r - len_pre - len_held;

  // Pick the byte at position idx_r of the expanded request.
  always_comb begin
    sel_byte = head_data.data;
    if (idx_r < len_pre) begin
      priority if (idx_r == 3'd0) begin
        sel_byte = upn_pkg::CH_PCT;
      end else if (idx_r == 3'd1) begin
        sel_byte = upn_pkg::CH_TWO;
      end else begin
        sel_byte = upn_pkg::CH_FIVE;
      end
    end else if (idx_r < len_pre + len_held) begin
      sel_byte = head_data.held;
    end else begin
      unique case (head_data.main)
        upn_pkg::MAIN_ESC: begin
          unique case (main_off[1:0])
            2'd0:    sel_byte = upn_pkg::CH_PCT;
            2'd1:    sel_byte = hex_char(head_data.data[7:4]);
            default: sel_byte = hex_char(head_data.data[3:0]);
          endcase
        end
        upn_pkg::MAIN_PCT25: begin
          unique case (main_off[1:0])
            2'd0:    sel_byte = upn_pkg::CH_PCT;
            2'd1:    sel_byte = upn_pkg::CH_TWO;
            default: sel_byte = upn_pkg::CH_FIVE;
          endcase
        end
        default: sel_byte = head_data.data;
      endcase
    end
  end

  assign load = !q_status.empty && (!out_valid_r || out_chan.ready);
  assign pop  = load && final_step;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      out_last_nxt  = head_data.last && final_step;
      idx_nxt       = final_step ? 3'd0 : idx_r + 3'd1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.out_last = out_last_r;

endmodule

FILE: rtl/core/url_percent_normalizer.sv
// Streaming URL percent normalizer. The front stage takes one input byte per cycle
// whenever the request queue (QUEUE_DEPTH entries) has room, and turns it into a
// request of zero to seven output bytes; the back stage sends one byte per cycle
// from its output register while a request waits and the receiver is ready. An input
// byte passed through yields 1 output byte, an escaped byte 3, and a broken escape
// that is flushed up to 7, so the back stage's output sets the throughput. A '%'
// and one hex digit may be held back with no output until the next byte decides
// their fate; the last byte of a string always flushes them, and out_last marks
// the final byte of the result.
`include "url_percent_normalizer_defines.svh"

module url_percent_normalizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  upn_in_if.sink     in_chan,
  upn_out_if.source  out_chan
);

  upn_pkg::upn_cmd_t      push_data;
  upn_pkg::upn_cmd_t      head_data;
  upn_pkg::upn_q_status_t q_status;
  logic                   push_valid;
  logic                   pop;
  logic                   mode_idle;

  upn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_data  (push_data),
    .mode_idle  (mode_idle)
  );

  upn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_status  (q_status)
  );

  upn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_data (head_data),
    .q_status  (q_status),
    .pop       (pop),
    .out_chan  (out_chan)
  );

  // A string never leaves anything pending behind its last byte.
  `UPN_ASSERT_NEXT(a_idle_after_last, in_chan.valid && in_chan.ready && in_chan.in_last, mode_idle)
  `UPN_ASSERT_IMPL(a_no_push_when_full, push_valid, !q_status.full)
  `UPN_ASSERT_IMPL(a_no_pop_when_empty, pop, !q_status.empty)

endmodule
